// ----- rtl/mvl_pkg.sv -----
// ----------------------------------------------------------------------------
// mvl_pkg
// Shared constants and types for the matrix-vector linear layer.
// ----------------------------------------------------------------------------
package mvl_pkg;

    localparam int MAX_LEN_DEF = 4096;
    localparam int COL_W       = 12;
    localparam int VAL_W       = 16;
    localparam int BIAS_W      = 32;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 44;
    localparam int RES_W       = 32;
    localparam int REG_W       = 13;
    localparam int COL_LIMIT   = 4096;

    localparam int QDEPTH      = 4;
    localparam int QPW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;

    localparam logic [REG_W-1:0] LENGTH_RST = 13'd2560;
    localparam logic [REG_W-1:0] ROWS_RST   = 13'd2560;
    localparam logic [REG_W-1:0] ROWS_CAP   = 13'd4096;

    typedef struct packed {
        logic signed [VAL_W-1:0]  weight;
        logic signed [VAL_W-1:0]  xval;
        logic                     col0;
        logic                     last;
        logic signed [BIAS_W-1:0] bias;
    } t_op;

    typedef struct packed {
        logic              valid;
        logic [QCW-1:0]    count;
    } t_q_status;

endpackage

// ----- rtl/mvl_if.sv -----
// ----------------------------------------------------------------------------
// mvl_if
// Valid/ready channels: input item, result item and configuration write.
// ----------------------------------------------------------------------------
interface mvl_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [mvl_pkg::COL_W-1:0]         col;
    logic signed [mvl_pkg::VAL_W-1:0]  value;
    logic signed [mvl_pkg::BIAS_W-1:0] bias_value;

    modport source(output valid, mode, col, value, bias_value, input ready);
    modport sink(input valid, mode, col, value, bias_value, output ready);
endinterface

interface mvl_out_if;
    logic                             valid;
    logic                             ready;
    logic [mvl_pkg::COL_W-1:0]        row;
    logic signed [mvl_pkg::RES_W-1:0] result_value;
    logic                             saturated;
    logic                             last_row;

    modport source(output valid, row, result_value, saturated, last_row, input ready);
    modport sink(input valid, row, result_value, saturated, last_row, output ready);
endinterface

interface mvl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mvl_pkg::CFG_IDX_W-1:0]     index;
    logic [mvl_pkg::REG_W-1:0]         data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/mvl_ram.sv -----
// ----------------------------------------------------------------------------
// mvl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mvl_front.sv -----
// ----------------------------------------------------------------------------
// mvl_front
// Accept items, store input elements, fetch the element for each weight.
// ----------------------------------------------------------------------------
module mvl_front #(
    parameter int MAX_LEN = mvl_pkg::MAX_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mvl_in_if.sink                      i_in,
    input  logic [mvl_pkg::REG_W-1:0]   i_length,
    input  mvl_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output mvl_pkg::t_op                o_op
);

    localparam int DEPTH = (MAX_LEN < mvl_pkg::COL_LIMIT) ? MAX_LEN : mvl_pkg::COL_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);
    localparam logic [mvl_pkg::REG_W-1:0] CAP_V = mvl_pkg::REG_W'(DEPTH);

    logic                              accept;
    logic                              in_len;
    logic                              do_write;
    logic                              do_read;
    logic [mvl_pkg::REG_W-1:0]         eff_len;
    logic [mvl_pkg::REG_W-1:0]         col_ext;
    logic [AW-1:0]                     addr;
    logic [mvl_pkg::VAL_W-1:0]         rdata;
    logic [mvl_pkg::QCW:0]             credit;

    logic                              r_s1_valid;
    logic signed [mvl_pkg::VAL_W-1:0]  r_weight;
    logic                              r_col0;
    logic                              r_last;
    logic signed [mvl_pkg::BIAS_W-1:0] r_bias;

    always_comb begin
        if (i_length == '0) begin
            eff_len = mvl_pkg::REG_W'(1);
        end else if (i_length > CAP_V) begin
            eff_len = CAP_V;
        end else begin
            eff_len = i_length;
        end
    end

    assign credit     = {1'b0, i_q_status.count} + (mvl_pkg::QCW + 1)'(r_s1_valid);
    assign i_in.ready = credit < (mvl_pkg::QCW + 1)'(mvl_pkg::QDEPTH);
    assign accept     = i_in.valid && i_in.ready;
    assign col_ext    = {1'b0, i_in.col};
    assign in_len     = col_ext < eff_len;
    assign do_write   = accept && !i_in.mode && ({5'b0, i_in.col} < MAX_LEN_V);
    assign do_read    = accept && i_in.mode && in_len;
    assign addr       = AW'(i_in.col);

    mvl_ram #(
        .WIDTH(mvl_pkg::VAL_W),
        .DEPTH(DEPTH)
    ) u_vec (
        .i_clk  (i_clk),
        .i_we   (do_write),
        .i_waddr(addr),
        .i_wdata(i_in.value),
        .i_re   (do_read),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= do_read;
        end
        if (do_read) begin
            r_weight <= i_in.value;
            r_col0   <= i_in.col == '0;
            r_last   <= col_ext == eff_len - mvl_pkg::REG_W'(1);
            r_bias   <= i_in.bias_value;
        end
    end

    assign o_push      = r_s1_valid;
    assign o_op.weight = r_weight;
    assign o_op.xval   = rdata;
    assign o_op.col0   = r_col0;
    assign o_op.last   = r_last;
    assign o_op.bias   = r_bias;

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> i_q_status.count < mvl_pkg::QCW'(mvl_pkg::QDEPTH))
        else $error("fetched weight finds the queue full");

endmodule

// ----- rtl/mvl_queue.sv -----
// ----------------------------------------------------------------------------
// mvl_queue
// Short FIFO of fetched weight operations between front and back.
// ----------------------------------------------------------------------------
module mvl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mvl_pkg::t_op       i_op,
    input  logic               i_pop,
    output mvl_pkg::t_q_status o_status,
    output mvl_pkg::t_op       o_op
);

    mvl_pkg::t_op               r_mem [mvl_pkg::QDEPTH];
    logic [mvl_pkg::QPW-1:0]    r_wptr;
    logic [mvl_pkg::QPW-1:0]    r_rptr;
    logic [mvl_pkg::QCW-1:0]    r_count;
    logic [mvl_pkg::QCW-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + mvl_pkg::QCW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - mvl_pkg::QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + mvl_pkg::QPW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + mvl_pkg::QPW'(1);
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    assign o_status.valid = r_count != '0;
    assign o_status.count = r_count;
    assign o_op           = r_mem[r_rptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> r_count != mvl_pkg::QCW'(mvl_pkg::QDEPTH))
        else $error("queue overflow");

endmodule

// ----- rtl/mvl_back.sv -----
// ----------------------------------------------------------------------------
// mvl_back
// Multiply, accumulate, saturate and emit one result per row.
// ----------------------------------------------------------------------------
module mvl_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mvl_pkg::t_q_status        i_q_status,
    input  mvl_pkg::t_op              i_op,
    output logic                      o_pop,
    input  logic [mvl_pkg::REG_W-1:0] i_rows,
    mvl_out_if.source                 o_out
);

    logic                               adv;
    logic [mvl_pkg::REG_W-1:0]          eff_rows;
    logic signed [mvl_pkg::ACC_W-1:0]   acc_base;
    logic signed [mvl_pkg::ACC_W-1:0]   n_acc;
    logic                               sat;
    logic signed [mvl_pkg::RES_W-1:0]   clamped;
    logic                               wrap;

    logic                               r_a_valid;
    logic signed [mvl_pkg::PROD_W-1:0]  r_a_prod;
    logic                               r_a_col0;
    logic                               r_a_last;
    logic signed [mvl_pkg::BIAS_W-1:0]  r_a_bias;

    logic signed [mvl_pkg::ACC_W-1:0]   r_acc;
    logic [mvl_pkg::COL_W-1:0]          r_row;

    logic                               r_out_valid;
    logic [mvl_pkg::COL_W-1:0]          r_out_row;
    logic signed [mvl_pkg::RES_W-1:0]   r_out_value;
    logic                               r_out_sat;
    logic                               r_out_last;

    always_comb begin
        if (i_rows == '0) begin
            eff_rows = mvl_pkg::REG_W'(1);
        end else if (i_rows > mvl_pkg::ROWS_CAP) begin
            eff_rows = mvl_pkg::ROWS_CAP;
        end else begin
            eff_rows = i_rows;
        end
    end

    assign adv   = !r_out_valid || o_out.ready;
    assign o_pop = adv && i_q_status.valid;

    always_comb begin
        acc_base = r_a_col0 ? mvl_pkg::ACC_W'(r_a_bias) : r_acc;
        n_acc    = acc_base + mvl_pkg::ACC_W'(r_a_prod);
        sat      = !((&n_acc[mvl_pkg::ACC_W-1:mvl_pkg::RES_W-1])
                  || (~|n_acc[mvl_pkg::ACC_W-1:mvl_pkg::RES_W-1]));
        if (!sat) begin
            clamped = n_acc[mvl_pkg::RES_W-1:0];
        end else if (n_acc[mvl_pkg::ACC_W-1]) begin
            clamped = {1'b1, {(mvl_pkg::RES_W-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(mvl_pkg::RES_W-1){1'b1}}};
        end
        wrap = ({1'b0, r_row} + mvl_pkg::REG_W'(1)) >= eff_rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_acc       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= i_q_status.valid;
            r_out_valid <= r_a_valid && r_a_last;
            if (r_a_valid) begin
                r_acc <= n_acc;
                if (r_a_last) begin
                    r_row <= wrap ? '0 : r_row + mvl_pkg::COL_W'(1);
                end
            end
        end
        if (adv) begin
            r_a_prod <= mvl_pkg::PROD_W'(i_op.weight * i_op.xval);
            r_a_col0 <= i_op.col0;
            r_a_last <= i_op.last;
            r_a_bias <= i_op.bias;
            if (r_a_valid && r_a_last) begin
                r_out_row   <= r_row;
                r_out_value <= clamped;
                r_out_sat   <= sat;
                r_out_last  <= wrap;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.row          = r_out_row;
    assign o_out.result_value = r_out_value;
    assign o_out.saturated    = r_out_sat;
    assign o_out.last_row     = r_out_last;

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out_value == 32'sh7fffffff || r_out_value == 32'sh80000000))
        else $error("saturated result not at a rail");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_a_valid && r_a_last && wrap) |=> r_row == '0)
        else $error("row counter did not wrap after last row");

    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_a_valid && r_a_last && !wrap) |=>
            r_row == $past(r_row) + mvl_pkg::COL_W'(1))
        else $error("row counter did not advance");

endmodule

// ----- rtl/matrix_vector_linear_layer.sv -----
// ----------------------------------------------------------------------------
// matrix_vector_linear_layer
// Fully connected layer out = W*x + b in Q4.12 / Q8.24 fixed point.
// ----------------------------------------------------------------------------
// Channels: i_in carries items (mode, col, value, bias_value); mode 0 stores
// an input-vector element, mode 1 streams a weight, row-major, columns
// ascending. o_out carries one result (row, result_value, saturated,
// last_row) per row, after the weight at the last column in use. i_cfg writes
// register 0 (length in use) and register 1 (rows in use); the user must do so
// only while idle, as the block itself does not enforce it.
// Throughput: one item per cycle while the queue has room, set by the single
// input-vector RAM read port and the one multiplier and accumulator in the back
// pipeline. After its last weight is accepted, a result passes the RAM read,
// then the queue, multiply, and accumulate into the output register.
// A 4-entry queue separates fetch from compute; when o_out stalls, the back
// holds and the front keeps accepting until the queue fills.
// Reset clears the accumulator, row counter, queue and valids and loads both
// registers with 2560; the input vector is undefined until written.
// ----------------------------------------------------------------------------
module matrix_vector_linear_layer #(
    parameter int MAX_LEN = mvl_pkg::MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvl_in_if.sink    i_in,
    mvl_cfg_if.sink   i_cfg,
    mvl_out_if.source o_out
);

    logic [mvl_pkg::REG_W-1:0] r_length;
    logic [mvl_pkg::REG_W-1:0] r_rows;
    logic                      push;
    logic                      pop;
    mvl_pkg::t_op              push_op;
    mvl_pkg::t_op              pop_op;
    mvl_pkg::t_q_status        q_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= mvl_pkg::LENGTH_RST;
            r_rows   <= mvl_pkg::ROWS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mvl_pkg::CFG_LENGTH: r_length <= i_cfg.data;
                mvl_pkg::CFG_ROWS:   r_rows   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mvl_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_length  (r_length),
        .i_q_status(q_status),
        .o_push    (push),
        .o_op      (push_op)
    );

    mvl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_status(q_status),
        .o_op    (pop_op)
    );

    mvl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(q_status),
        .i_op      (pop_op),
        .o_pop     (pop),
        .i_rows    (r_rows),
        .o_out     (o_out)
    );

endmodule
